// ----- rtl/core/alpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_pkg
// Shared types, constants and helpers for the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
package alpe_pkg;

   localparam int TICK_BITS    = 10;
   localparam int PIX_BITS     = 24;
   localparam int COLOR_BITS   = 8;
   localparam int BIT_IDX_BITS = $clog2(PIX_BITS + 1);
   localparam int CSR_IDX_BITS = 2;
   localparam int RSP_BITS     = 8;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TICK_BITS-1:0] ONE_HIGH_RESET  = TICK_BITS'(70);
   localparam logic [TICK_BITS-1:0] ONE_LOW_RESET   = TICK_BITS'(60);
   localparam logic [TICK_BITS-1:0] ZERO_HIGH_RESET = TICK_BITS'(35);
   localparam logic [TICK_BITS-1:0] ZERO_LOW_RESET  = TICK_BITS'(90);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ONE_HIGH  = 2'd0,
      REG_ONE_LOW   = 2'd1,
      REG_ZERO_HIGH = 2'd2,
      REG_ZERO_LOW  = 2'd3
   } reg_idx_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_PUSH = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PIX_BITS-1:0] pixel;
   } item_type;

   // a duration of zero counts as one tick
   function automatic logic [TICK_BITS-1:0] dur(input logic [TICK_BITS-1:0] v);
      return (v == '0) ? TICK_BITS'(1) : v;
   endfunction

endpackage

// ----- rtl/core/alpe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_front
// Classifies incoming transactions as tick or pixel push and packs the
// pixel bytes in green, red, blue order for the queue.
// ----------------------------------------------------------------------------
module alpe_front (
   input  logic                            req_tuser,
   input  logic [alpe_pkg::PIX_BITS-1:0]   req_tdata,
   output alpe_pkg::item_type              item
);
   import alpe_pkg::*;

   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;

   assign red   = req_tdata[COLOR_BITS-1:0];
   assign green = req_tdata[2*COLOR_BITS-1:COLOR_BITS];
   assign blue  = req_tdata[3*COLOR_BITS-1:2*COLOR_BITS];

   always_comb begin
      item.op    = req_tuser ? OP_PUSH : OP_TICK;
      // green goes out first, so it sits in the top byte
      item.pixel = req_tuser ? {green, red, blue} : '0;
   end

endmodule

// ----- rtl/core/alpe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_queue
// Short FIFO between the classifier and the pulse engine.
// ----------------------------------------------------------------------------
module alpe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  alpe_pkg::item_type wr_item,
   output logic               full,
   input  logic               rd_en,
   output logic               rd_valid,
   output alpe_pkg::item_type rd_item
);
   import alpe_pkg::*;

   item_type              mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/core/alpe_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_engine
// Pulse engine: holds timing registers, holding register and bit shifter;
// advances one transaction per cycle to the output register unless it stalls.
// ----------------------------------------------------------------------------
module alpe_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [alpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [alpe_pkg::TICK_BITS-1:0]     csr_wdata,
   input  logic                               q_valid,
   input  alpe_pkg::item_type                 q_item,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [alpe_pkg::RSP_BITS-1:0]      rsp_tdata
);
   import alpe_pkg::*;

   logic [TICK_BITS-1:0]    one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;

   logic [PIX_BITS-1:0]     shift_ff, shift_in;
   logic [BIT_IDX_BITS-1:0] bit_idx_ff, bit_idx_in;
   logic                    high_ff, high_in;
   logic [TICK_BITS-1:0]    left_ff, left_in;
   logic                    sending_ff, sending_in;
   logic [PIX_BITS-1:0]     held_ff, held_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    accepted;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]     rsp_data_ff, rsp_data_in;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= ONE_HIGH_RESET;
         one_low_ff   <= ONE_LOW_RESET;
         zero_high_ff <= ZERO_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_ONE_HIGH:  one_high_ff  <= csr_wdata;
            REG_ONE_LOW:   one_low_ff   <= csr_wdata;
            REG_ZERO_HIGH: zero_high_ff <= csr_wdata;
            REG_ZERO_LOW:  zero_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      bit_idx_in    = bit_idx_ff;
      high_in       = high_ff;
      left_in       = left_ff;
      sending_in    = sending_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      accepted      = 1'b0;

      if (q_pop) begin
         if (q_item.op == OP_PUSH) begin
            if (!held_valid_ff) begin
               held_in       = q_item.pixel;
               held_valid_in = 1'b1;
               accepted      = 1'b1;
            end
         end else begin
            if (sending_ff) begin
               left_in = left_ff - 1'b1;
               if (left_in == '0) begin
                  if (high_ff) begin
                     high_in = 1'b0;
                     left_in = shift_ff[PIX_BITS-1] ? dur(one_low_ff) : dur(zero_low_ff);
                  end else begin
                     bit_idx_in = bit_idx_ff + 1'b1;
                     shift_in   = {shift_ff[PIX_BITS-2:0], 1'b0};
                     if (bit_idx_in == BIT_IDX_BITS'(PIX_BITS)) begin
                        sending_in = 1'b0;
                        high_in    = 1'b0;
                        bit_idx_in = '0;
                     end else begin
                        high_in = 1'b1;
                        left_in = shift_in[PIX_BITS-1] ? dur(one_high_ff)
                                                       : dur(zero_high_ff);
                     end
                  end
               end
            end
            // back-to-back pixels: load on the same tick the last one ends
            if (!sending_in && held_valid_ff) begin
               shift_in      = held_ff;
               held_valid_in = 1'b0;
               bit_idx_in    = '0;
               sending_in    = 1'b1;
               high_in       = 1'b1;
               left_in       = held_ff[PIX_BITS-1] ? dur(one_high_ff) : dur(zero_high_ff);
            end
         end
      end

      rsp_data_in = {{(RSP_BITS-4){1'b0}}, held_valid_in, accepted, sending_in,
                     sending_in && high_in};
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         bit_idx_ff    <= '0;
         high_ff       <= 1'b0;
         left_ff       <= '0;
         sending_ff    <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         bit_idx_ff    <= bit_idx_in;
         high_ff       <= high_in;
         left_ff       <= left_in;
         sending_ff    <= sending_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- rtl/core/addressable_led_pulse_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder
// Single-wire addressable LED encoder: tick and pixel-push transactions in,
// one line-state result out per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while ready is high and returns exactly one
// result for each, in order. A transaction passes the classifier into a
// two-entry queue and is executed by the pulse engine, whose state update
// sets the rate of one transaction per cycle; the engine registers the result
// as it pops the entry. Ready stays high while the queue has room, so a stalled
// result side lets up to two more transactions in before backpressure reaches
// req. Timing registers may be rewritten only while no transaction is in flight.
module addressable_led_pulse_encoder (
   input  logic                               clock,
   input  logic                               reset,
   // csr write port
   input  logic                               csr_we,
   input  logic [alpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [alpe_pkg::TICK_BITS-1:0]     csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [alpe_pkg::PIX_BITS-1:0]      req_tdata,  // red, green, blue
   input  logic                               req_tuser,  // action (1 = push pixel)
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [alpe_pkg::RSP_BITS-1:0]      rsp_tdata   // line_level, busy_res,
                                                           // pixel_accepted, pending_full
);
   import alpe_pkg::*;

   item_type front_item;
   item_type q_item;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;

   assign req_tready = !q_full;

   alpe_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .item      (front_item)
   );

   alpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_tvalid),
      .wr_item  (front_item),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_item  (q_item)
   );

   alpe_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/core/alpe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpe_checker
// Port-level checks for the addressable LED pulse encoder.
// ----------------------------------------------------------------------------
module alpe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [alpe_pkg::RSP_BITS-1:0]      rsp_tdata
);
   import alpe_pkg::*;

   // line can only be high while a pixel is going out
   a_line_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("line high while not busy");

   // a taken pixel must show up in the holding register
   a_accept_fills_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[3])
      else $error("pixel accepted but holding register empty");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_BITS-1:4] == '0))
      else $error("response pad bits not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind addressable_led_pulse_encoder alpe_checker u_alpe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb_addressable_led_pulse_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_pulse_encoder
// Streams tick and pixel-push transactions into the LED encoder under random
// handshake gaps and long backpressure. A line-state predictor follows the
// pulse timing per transaction and each response is checked against it.
// ----------------------------------------------------------------------------
module tb_addressable_led_pulse_encoder;
   import alpe_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int ITEMS_PER_SET = 265;

   // one response, lowest field in the lowest bit
   typedef struct packed {
      logic pending_full;
      logic pixel_accepted;
      logic busy;
      logic line_level;
   } line_state_type;

   class led_line_predictor;
      logic [TICK_BITS-1:0] one_high, one_low, zero_high, zero_low;
      logic [PIX_BITS-1:0]  shifter, held_pixel;
      logic [TICK_BITS-1:0] ticks_left;
      int                   bits_done;
      bit                   high_phase, sending, held_full;
      line_state_type       line_state_q[$];
      int                   errors;

      function new();
         one_high   = ONE_HIGH_RESET;
         one_low    = ONE_LOW_RESET;
         zero_high  = ZERO_HIGH_RESET;
         zero_low   = ZERO_LOW_RESET;
         shifter    = '0;
         held_pixel = '0;
         ticks_left = '0;
         bits_done  = 0;
         high_phase = 1'b0;
         sending    = 1'b0;
         held_full  = 1'b0;
         errors     = 0;
      endfunction

      function void set_timing(reg_idx_type idx, logic [TICK_BITS-1:0] v);
         case (idx)
            REG_ONE_HIGH:  one_high  = v;
            REG_ONE_LOW:   one_low   = v;
            REG_ZERO_HIGH: zero_high = v;
            REG_ZERO_LOW:  zero_low  = v;
            default: ;
         endcase
      endfunction

      function logic [TICK_BITS-1:0] at_least_one(logic [TICK_BITS-1:0] v);
         return (v == '0) ? TICK_BITS'(1) : v;
      endfunction

      function void start_high();
         high_phase = 1'b1;
         ticks_left = shifter[PIX_BITS-1] ? at_least_one(one_high) : at_least_one(zero_high);
      endfunction

      function void advance_tick();
         if (sending) begin
            ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
               if (high_phase) begin
                  high_phase = 1'b0;
                  ticks_left = shifter[PIX_BITS-1] ? at_least_one(one_low)
                                                   : at_least_one(zero_low);
               end else begin
                  bits_done++;
                  shifter = shifter << 1;
                  if (bits_done >= PIX_BITS) begin
                     sending    = 1'b0;
                     high_phase = 1'b0;
                     bits_done  = 0;
                  end else begin
                     start_high();
                  end
               end
            end
         end
         // back-to-back pixels: the held one starts on this same tick
         if (!sending && held_full) begin
            shifter   = held_pixel;
            held_full = 1'b0;
            bits_done = 0;
            sending   = 1'b1;
            start_high();
         end
      endfunction

      function void note_item(op_type op, logic [23:0] data);
         line_state_type st;
         st.pixel_accepted = 1'b0;
         if (op == OP_PUSH) begin
            if (!held_full) begin
               // sent green, red, blue from the top bit down
               held_pixel        = {data[15:8], data[7:0], data[23:16]};
               held_full         = 1'b1;
               st.pixel_accepted = 1'b1;
            end
         end else begin
            advance_tick();
         end
         st.line_level   = sending && high_phase;
         st.busy         = sending;
         st.pending_full = held_full;
         line_state_q.push_back(st);
      endfunction

      function void compare_bit(string field, logic exp_v, logic act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, exp_v, act_v);
         end
      endfunction

      function void check_line_state(logic [RSP_BITS-1:0] rsp);
         line_state_type exp_st, act_st;
         if (line_state_q.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, actual %h", $time, rsp);
            return;
         end
         exp_st = line_state_q.pop_front();
         act_st = rsp[3:0];
         compare_bit("line_level", exp_st.line_level, act_st.line_level);
         compare_bit("busy_res", exp_st.busy, act_st.busy);
         compare_bit("pixel_accepted", exp_st.pixel_accepted, act_st.pixel_accepted);
         compare_bit("pending_full", exp_st.pending_full, act_st.pending_full);
      endfunction

      function int outstanding();
         return line_state_q.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [TICK_BITS-1:0]    csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [PIX_BITS-1:0]     req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_BITS-1:0]     rsp_tdata;

   led_line_predictor line_model = new();

   bit quiet_mode = 1'b0;
   bit hold_req   = 1'b0;
   bit hold_ack   = 1'b0;
   int hold_left  = 0;
   int rsp_idle   = 0;
   int cycle_count = 0;

   addressable_led_pulse_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_idle != 0) begin
         rsp_tready <= 1'b0;
         rsp_idle   <= rsp_idle - 1;
      end else if (!quiet_mode && $urandom_range(99) < 6) begin
         rsp_tready <= 1'b0;
         rsp_idle   <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         line_model.check_line_state(rsp_tdata);
   end

   task automatic offer_item(op_type op, logic [23:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      line_model.note_item(op, data);
      if (!quiet_mode && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // mostly keep the holding register fed; the odd push onto a full one
   task automatic random_item();
      bit do_push;
      do_push = line_model.held_full ? ($urandom_range(39) == 0) : ($urandom_range(9) == 0);
      offer_item(do_push ? OP_PUSH : OP_TICK, 24'($urandom));
   endtask

   task automatic wait_all_results();
      while (line_model.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [TICK_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      line_model.set_timing(idx, v);
   endtask

   task automatic program_timing(logic [TICK_BITS-1:0] oh, logic [TICK_BITS-1:0] ol,
                                 logic [TICK_BITS-1:0] zh, logic [TICK_BITS-1:0] zl);
      req_tvalid <= 1'b0;
      wait_all_results();
      repeat (4) @(posedge clock);
      write_reg(REG_ONE_HIGH, oh);
      write_reg(REG_ONE_LOW, ol);
      write_reg(REG_ZERO_HIGH, zh);
      write_reg(REG_ZERO_LOW, zl);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n_items;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_TICK;
      req_tdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset timing: idle tick, extremes, push onto a full holding register
      offer_item(OP_TICK, 24'hFFFFFF);
      offer_item(OP_PUSH, 24'hFFFFFF);
      offer_item(OP_PUSH, 24'h000000);
      offer_item(OP_TICK, 24'h000000);
      offer_item(OP_PUSH, 24'h000000);
      offer_item(OP_PUSH, 24'hA55AC3);
      offer_item(OP_TICK, 24'h3C3C3C);
      offer_item(OP_TICK, 24'hC3C3C3);

      // zero durations behave as one tick
      program_timing('0, '0, '0, '0);
      offer_item(OP_PUSH, 24'h00FF00);
      repeat (14) offer_item(OP_TICK, 24'($urandom));
      offer_item(OP_PUSH, 24'h0000FF);
      repeat (2) offer_item(OP_TICK, 24'($urandom));

      for (int set_no = 0; set_no < 8; set_no++) begin
         n_items = ITEMS_PER_SET;
         case (set_no)
            0: program_timing(10'd1, 10'd1, 10'd1, 10'd1);
            1: program_timing(10'($urandom_range(1, 3)), 10'($urandom_range(1, 3)),
                              10'($urandom_range(1, 3)), 10'($urandom_range(1, 3)));
            2: begin
               program_timing(10'd1023, 10'd1023, 10'd1023, 10'd1023);
               n_items = 120;
            end
            3: begin
               program_timing(10'd1, 10'd1023, 10'd1023, 10'd1);
               n_items = 120;
            end
            4: program_timing(10'($urandom_range(1, 5)), 10'($urandom_range(1, 5)),
                              10'($urandom_range(1, 5)), 10'($urandom_range(1, 5)));
            5: program_timing(10'd2, 10'd1, 10'd1, 10'd2);
            6: program_timing(10'($urandom_range(1, 3)), 10'($urandom_range(1, 3)),
                              10'($urandom_range(1, 3)), 10'($urandom_range(1, 3)));
            default: program_timing('0, '0, '0, '0);
         endcase
         quiet_mode <= (set_no == 0);
         for (int k = 0; k < n_items; k++) begin
            // long receiver hold-off while transactions keep coming
            if (set_no == 4 && k == 60)
               hold_req <= ~hold_req;
            if (set_no == 6 && k == 110) begin
               req_tvalid <= 1'b0;
               wait_all_results();
            end
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      wait_all_results();
      repeat (10) @(posedge clock);
      if (line_model.errors == 0 && line_model.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/alpe_pkg.sv
rtl/core/alpe_front.sv
rtl/core/alpe_queue.sv
rtl/core/alpe_engine.sv
rtl/core/addressable_led_pulse_encoder.sv
rtl/core/alpe_checker.sv
tb/tb_addressable_led_pulse_encoder.sv
